### rtl/core/bdq_pkg.sv
package bdq_pkg;

   // Default ring depth
   localparam int DEPTH_DEFAULT = 256;

   // Operation codes carried in the request mode field
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
   localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
   localparam logic [2:0] MODE_POP_BACK   = 3'd2;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
   localparam logic [2:0] MODE_READ       = 3'd4;

   // One request
   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] value;
      logic [7:0] position;
   } req_type;

   // One result
   typedef struct packed {
      logic [7:0] data;
      logic       ok;
      logic [8:0] occupancy;
   } rsp_type;

   // Controller states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic respond;
   } cmd_type;

endpackage

### rtl/core/byte_deque_with_indexed_read_top.sv
// Byte deque with indexed read. Pulse start while busy is low to issue one
// request (push back, push front, pop back, pop front, or read at a position
// counted from the front). Each request passes through an accept state, a
// ring memory access state and a response state in which rsp_valid is high
// for a single cycle with the result; busy stays high until that response
// cycle has passed, so no new request is accepted while one is in flight. The
// result cannot be stalled: sample it whenever rsp_valid is high. A failed
// operation (full push, empty pop, read past the held count, unused mode)
// leaves the queue unchanged and returns ok low with data zero. The ring
// contents are not cleared after reset; only written slots are ever returned.
module byte_deque_with_indexed_read_top #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bdq_pkg::req_type req_payload,
   output logic             rsp_valid,
   output bdq_pkg::rsp_type rsp_payload
);
   import bdq_pkg::*;

   cmd_type cmd;

   bdq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   bdq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

   // Strobe the result in the response cycle
   assign rsp_valid = cmd.respond;

endmodule

### rtl/core/bdq_ctrl.sv
module bdq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output bdq_pkg::cmd_type cmd
);
   import bdq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Step through load, execute and respond for each request
   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = start ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Drive commands and the busy flag
   always_comb begin
      cmd.load    = start && (state_ff == ST_IDLE);
      cmd.exec    = (state_ff == ST_EXEC);
      cmd.respond = (state_ff == ST_RESP);
      busy        = (state_ff != ST_IDLE);
   end

endmodule

### rtl/core/bdq_datapath.sv
module bdq_datapath #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  bdq_pkg::cmd_type cmd,
   input  bdq_pkg::req_type req_payload,
   output bdq_pkg::rsp_type rsp_payload
);
   import bdq_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam int CW = (FW > 8) ? FW : 8;
   localparam logic [PW:0]   DEPTH_W = (PW + 1)'(DEPTH);
   localparam logic [PW-1:0] LAST    = PW'(DEPTH - 1);
   localparam logic [FW-1:0] FULL    = FW'(DEPTH);

   logic [7:0]    mem [DEPTH];
   req_type       req_ff;
   logic [PW-1:0] head_ff;
   logic [PW-1:0] head_in;
   logic [FW-1:0] fill_ff;
   logic [FW-1:0] fill_in;
   logic [7:0]    rd_ff;
   logic          rdsel_ff;
   logic          ok_ff;

   logic          full;
   logic          empty;
   logic          in_range;
   logic [PW-1:0] offset;
   logic [PW:0]   sum;
   logic [PW:0]   wrapped;
   logic [PW-1:0] slot;
   logic          we;
   logic          ok;
   logic          rdsel;

   // Hold the request while it executes
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
   end

   assign full     = (fill_ff == FULL);
   assign empty    = (fill_ff == '0);
   assign in_range = CW'(req_ff.position) < CW'(fill_ff);

   // Map a logical offset from the front onto a ring slot
   assign sum     = {1'b0, head_ff} + {1'b0, offset};
   assign wrapped = (sum >= DEPTH_W) ? (sum - DEPTH_W) : sum;

   // Decode the operation
   always_comb begin
      offset  = '0;
      slot    = wrapped[PW-1:0];
      we      = 1'b0;
      ok      = 1'b0;
      rdsel   = 1'b0;
      head_in = head_ff;
      fill_in = fill_ff;
      unique case (req_ff.mode)
         MODE_PUSH_BACK: begin
            offset = fill_ff[PW-1:0];
            slot   = wrapped[PW-1:0];
            if (!full) begin
               we      = 1'b1;
               ok      = 1'b1;
               fill_in = fill_ff + 1'b1;
            end
         end
         MODE_PUSH_FRONT: begin
            slot = (head_ff == '0) ? LAST : (head_ff - 1'b1);
            if (!full) begin
               we      = 1'b1;
               ok      = 1'b1;
               head_in = slot;
               fill_in = fill_ff + 1'b1;
            end
         end
         MODE_POP_BACK: begin
            offset = PW'(fill_ff - 1'b1);
            slot   = wrapped[PW-1:0];
            if (!empty) begin
               ok      = 1'b1;
               rdsel   = 1'b1;
               fill_in = fill_ff - 1'b1;
            end
         end
         MODE_POP_FRONT: begin
            slot = head_ff;
            if (!empty) begin
               ok      = 1'b1;
               rdsel   = 1'b1;
               head_in = (head_ff == LAST) ? '0 : (head_ff + 1'b1);
               fill_in = fill_ff - 1'b1;
            end
         end
         MODE_READ: begin
            offset = PW'(req_ff.position);
            slot   = wrapped[PW-1:0];
            if (in_range) begin
               ok    = 1'b1;
               rdsel = 1'b1;
            end
         end
         default: begin
            slot = head_ff;
         end
      endcase
   end

   // Access the ring: write pushes, register the read word
   always_ff @(posedge clock) begin
      if (cmd.exec && we) begin
         mem[slot] <= req_ff.value;
      end
      if (cmd.exec) begin
         rd_ff <= mem[slot];
      end
   end

   // Update pointer and count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else if (cmd.exec) begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   // Hold result flags for the response cycle
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         ok_ff    <= ok;
         rdsel_ff <= rdsel;
      end
   end

   assign rsp_payload.data      = rdsel_ff ? rd_ff : 8'd0;
   assign rsp_payload.ok        = ok_ff;
   assign rsp_payload.occupancy = 9'(fill_ff);

endmodule

### rtl/core/bdq_checker.sv
module bdq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input bdq_pkg::rsp_type rsp_payload
);
   import bdq_pkg::*;

   logic    accept;

   assign accept     = start && !busy;

   // Each accepted request yields its response after passing the execute state
   a_resp_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("response missing two cycles after request");

   // An accepted request makes the block busy once the state register leaves idle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after request");

   // Strobe lasts one cycle
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // Failed operations return zero data
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.ok) |-> (rsp_payload.data == 8'd0))
      else $error("failed operation returned nonzero data");

endmodule

bind byte_deque_with_indexed_read_top bdq_checker u_bdq_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);
